/* sv/zcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// zcd_pkg
// Shared types and constants for the zip central directory record parser.
// ----------------------------------------------------------------------------
package zcd_pkg;

   localparam logic [31:0] MAX_ARCHIVE_BYTES_DEF = 32'd268435456;

   localparam int unsigned CFG_BITS       = 29;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned RSP_TDATA_BITS = 152;
   localparam int unsigned REQ_TDATA_BITS = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ARCHIVE_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIRECTORY_START = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENTRY_COUNT     = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DAMAGED   = 2'd1;
   localparam logic [1:0] STATUS_NAME_PAST = 2'd2;
   localparam logic [1:0] STATUS_ENCRYPTED = 2'd3;

   localparam logic [31:0] RECORD_SIGNATURE  = 32'h02014b50;
   localparam logic [5:0]  HEADER_BYTES      = 6'd46;
   localparam logic [5:0]  HEADER_LAST       = 6'd45;
   localparam int unsigned FLAG_ENCRYPTED_BIT = 0;
   localparam int unsigned FLAG_UTF8_BIT      = 11;

   localparam logic [5:0] OFS_SIGNATURE = 6'd0;
   localparam logic [5:0] OFS_FLAGS     = 6'd8;
   localparam logic [5:0] OFS_METHOD    = 6'd10;
   localparam logic [5:0] OFS_COMP      = 6'd20;
   localparam logic [5:0] OFS_UNCOMP    = 6'd24;
   localparam logic [5:0] OFS_NAME      = 6'd28;
   localparam logic [5:0] OFS_EXTRA     = 6'd30;
   localparam logic [5:0] OFS_COMMENT   = 6'd32;
   localparam logic [5:0] OFS_LOCAL     = 6'd42;

   typedef struct packed {
      logic [31:0] signature;
      logic        encrypted;
      logic        utf8_name;
      logic [15:0] method;
      logic [31:0] compressed_size;
      logic [31:0] uncompressed_size;
      logic [15:0] name_length;
      logic [15:0] extra_length;
      logic [15:0] comment_length;
      logic [31:0] local_offset;
   } header_type;

   typedef struct packed {
      logic [15:0] entry_index;
      logic [15:0] method;
      logic        utf8_name;
      logic [31:0] compressed_size;
      logic [31:0] uncompressed_size;
      logic [31:0] local_offset;
      logic [15:0] name_length;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic idle;
      logic skipping;
   } ctrl_status_type;

endpackage
`default_nettype wire

/* sv/zcd_header_capture.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// zcd_header_capture
// Holds the fixed header fields of the current record, loaded byte by byte.
// ----------------------------------------------------------------------------
module zcd_header_capture (
   input  wire logic              clock,
   input  wire logic              capture_en,
   input  wire logic [5:0]        position,
   input  wire logic [7:0]        data_byte,
   output zcd_pkg::header_type    header
);
   import zcd_pkg::*;

   header_type header_ff;
   header_type header_in;

   always_comb begin
      logic [5:0] rel_sig;
      logic [5:0] rel_method;
      logic [5:0] rel_comp;
      logic [5:0] rel_uncomp;
      logic [5:0] rel_name;
      logic [5:0] rel_extra;
      logic [5:0] rel_comment;
      logic [5:0] rel_local;
      rel_sig     = position - OFS_SIGNATURE;
      rel_method  = position - OFS_METHOD;
      rel_comp    = position - OFS_COMP;
      rel_uncomp  = position - OFS_UNCOMP;
      rel_name    = position - OFS_NAME;
      rel_extra   = position - OFS_EXTRA;
      rel_comment = position - OFS_COMMENT;
      rel_local   = position - OFS_LOCAL;
      header_in   = header_ff;
      if (capture_en) begin
         if (position < OFS_SIGNATURE + 6'd4) begin
            header_in.signature[{rel_sig[1:0], 3'b000} +: 8] = data_byte;
         end
         if (position == OFS_FLAGS) begin
            header_in.encrypted = data_byte[FLAG_ENCRYPTED_BIT];
         end
         if (position == OFS_FLAGS + 6'd1) begin
            header_in.utf8_name = data_byte[FLAG_UTF8_BIT-8];
         end
         if (position >= OFS_METHOD && position < OFS_METHOD + 6'd2) begin
            header_in.method[{rel_method[0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_COMP && position < OFS_COMP + 6'd4) begin
            header_in.compressed_size[{rel_comp[1:0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_UNCOMP && position < OFS_UNCOMP + 6'd4) begin
            header_in.uncompressed_size[{rel_uncomp[1:0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_NAME && position < OFS_NAME + 6'd2) begin
            header_in.name_length[{rel_name[0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_EXTRA && position < OFS_EXTRA + 6'd2) begin
            header_in.extra_length[{rel_extra[0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_COMMENT && position < OFS_COMMENT + 6'd2) begin
            header_in.comment_length[{rel_comment[0], 3'b000} +: 8] = data_byte;
         end
         if (position >= OFS_LOCAL && position < OFS_LOCAL + 6'd4) begin
            header_in.local_offset[{rel_local[1:0], 3'b000} +: 8] = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
   end

   // includes the byte being taken this cycle
   assign header = header_in;

endmodule
`default_nettype wire

/* sv/zcd_record_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// zcd_record_ctrl
// Walks records: byte position, skip count, bound checks and result fields.
// ----------------------------------------------------------------------------
module zcd_record_ctrl #(
   parameter logic [31:0] MAX_ARCHIVE_BYTES = zcd_pkg::MAX_ARCHIVE_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_fire,
   input  wire logic [zcd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [zcd_pkg::CFG_BITS-1:0]          csr_wdata,
   input  wire logic                                  step,
   input  wire logic [7:0]                            data_byte,
   output logic                                       emit,
   output zcd_pkg::result_type                        result,
   output zcd_pkg::ctrl_status_type                   status
);
   import zcd_pkg::*;

   logic [28:0] archive_ff, archive_in;
   logic [28:0] dir_ff, dir_in;
   logic [15:0] count_ff, count_in;
   logic [32:0] offset_ff, offset_in;
   logic [5:0]  pos_ff, pos_in;
   logic [17:0] skip_ff, skip_in;
   logic [15:0] entries_ff, entries_in;
   logic        finished_ff, finished_in;

   logic        capture_en;
   logic        idle;
   logic [28:0] bound;
   logic [33:0] hdr_end;
   header_type  header;

   zcd_header_capture u_capture (
      .clock      (clock),
      .capture_en (capture_en),
      .position   (pos_ff),
      .data_byte  (data_byte),
      .header     (header)
   );

   assign bound   = ({3'b000, archive_ff} > MAX_ARCHIVE_BYTES) ? MAX_ARCHIVE_BYTES[28:0]
                                                                 : archive_ff;
   assign hdr_end = {1'b0, offset_ff} + {28'd0, HEADER_BYTES};
   assign idle    = finished_ff || (entries_ff >= count_ff);

   always_comb begin
      logic [33:0] name_end;
      logic [17:0] skip_sum;
      logic [33:0] next_offset;
      logic [16:0] entries_next;
      name_end     = hdr_end + {18'd0, header.name_length};
      skip_sum     = {2'b00, header.name_length} + {2'b00, header.extra_length}
                   + {2'b00, header.comment_length};
      next_offset  = hdr_end + {16'd0, skip_sum};
      entries_next = {1'b0, entries_ff} + 17'd1;

      archive_in  = archive_ff;
      dir_in      = dir_ff;
      count_in    = count_ff;
      offset_in   = offset_ff;
      pos_in      = pos_ff;
      skip_in     = skip_ff;
      entries_in  = entries_ff;
      finished_in = finished_ff;
      capture_en  = 1'b0;
      emit        = 1'b0;
      result      = '0;
      result.entry_index = entries_ff;

      if (csr_fire) begin
         unique case (csr_index)
            REG_ARCHIVE_SIZE: begin
               archive_in = csr_wdata;
            end
            REG_DIRECTORY_START: begin
               dir_in = csr_wdata;
            end
            REG_ENTRY_COUNT: begin
               count_in = csr_wdata[15:0];
            end
            default: begin
            end
         endcase
         if (csr_index == REG_ARCHIVE_SIZE || csr_index == REG_DIRECTORY_START ||
             csr_index == REG_ENTRY_COUNT) begin
            offset_in   = {4'd0, dir_in};
            pos_in      = '0;
            skip_in     = '0;
            entries_in  = '0;
            finished_in = 1'b0;
         end
      end else if (step && !idle) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - 18'd1;
         end else if (pos_ff == '0 && hdr_end > {5'd0, bound}) begin
            emit          = 1'b1;
            result.status = STATUS_DAMAGED;
            result.last   = 1'b1;
            finished_in   = 1'b1;
         end else begin
            capture_en = 1'b1;
            if (pos_ff != HEADER_LAST) begin
               pos_in = pos_ff + 6'd1;
            end else begin
               pos_in = '0;
               emit   = 1'b1;
               if (header.signature != RECORD_SIGNATURE) begin
                  result.status = STATUS_DAMAGED;
                  result.last   = 1'b1;
                  finished_in   = 1'b1;
               end else begin
                  result.method            = header.method;
                  result.utf8_name         = header.utf8_name;
                  result.compressed_size   = header.compressed_size;
                  result.uncompressed_size = header.uncompressed_size;
                  result.local_offset      = header.local_offset;
                  result.name_length       = header.name_length;
                  priority if (name_end > {5'd0, bound}) begin
                     result.status = STATUS_NAME_PAST;
                  end else if (header.encrypted) begin
                     result.status = STATUS_ENCRYPTED;
                  end else begin
                     result.status = STATUS_OK;
                  end
                  if (result.status != STATUS_OK) begin
                     result.last = 1'b1;
                     finished_in = 1'b1;
                  end else begin
                     skip_in     = skip_sum;
                     offset_in   = next_offset[32:0];
                     entries_in  = entries_next[15:0];
                     result.last = (entries_next[15:0] >= count_ff);
                     finished_in = result.last;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         archive_ff  <= '0;
         dir_ff      <= '0;
         count_ff    <= '0;
         offset_ff   <= '0;
         pos_ff      <= '0;
         skip_ff     <= '0;
         entries_ff  <= '0;
         finished_ff <= 1'b0;
      end else begin
         archive_ff  <= archive_in;
         dir_ff      <= dir_in;
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         pos_ff      <= pos_in;
         skip_ff     <= skip_in;
         entries_ff  <= entries_in;
         finished_ff <= finished_in;
      end
   end

   assign status.idle     = idle;
   assign status.skipping = (skip_ff != '0);

endmodule
`default_nettype wire

/* sv/zip_central_directory_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Parses central directory records from an archive byte stream.
// the byte completing a result passes the input byte register, then the result register
// throughput: one byte per cycle unless a held result waits on rsp_tready
// reset: synchronous active high; state registers zero, parser idle until configured
// ----------------------------------------------------------------------------
module zip_central_directory_parser #(
   parameter logic [31:0] MAX_ARCHIVE_BYTES = zcd_pkg::MAX_ARCHIVE_BYTES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // data_byte
   input  wire logic [zcd_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // entry_index, method, utf8_name, compressed_size, uncompressed_size,
   // local_offset, name_length, zero fill
   output logic [zcd_pkg::RSP_TDATA_BITS-1:0]         rsp_tdata,
   // status
   output logic [1:0]                                 rsp_tuser,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [zcd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [zcd_pkg::CFG_BITS-1:0]          csr_wdata
);
   import zcd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff, in_byte_in;
   logic            out_valid_ff, out_valid_in;
   result_type      out_result_ff, out_result_in;

   logic            step;
   logic            req_fire;
   logic            csr_fire;
   logic            emit;
   logic            out_load;
   result_type      result;
   ctrl_status_type ctrl_status;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = step && emit;

   zcd_record_ctrl #(
      .MAX_ARCHIVE_BYTES (MAX_ARCHIVE_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_fire),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result),
      .status    (ctrl_status)
   );

   always_comb begin
      in_byte_in    = req_fire ? req_tdata[7:0] : in_byte_ff;
      in_valid_in   = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_result_in = out_load ? result : out_result_ff;
      out_valid_in  = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff    <= in_byte_in;
      out_result_ff <= out_result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_result_ff.name_length,
                        out_result_ff.local_offset,
                        out_result_ff.uncompressed_size,
                        out_result_ff.compressed_size,
                        out_result_ff.utf8_name,
                        out_result_ff.method,
                        out_result_ff.entry_index};
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tlast  = out_result_ff.last;

   // any error ends the run
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tlast)
      else $error("error result without last");

   // after the final result the parser takes no further records
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      out_load && result.last && !csr_fire |=> ctrl_status.idle)
      else $error("parser still active after last result");

   // bytes being skipped never produce a result
   a_skip_silent: assert property (@(posedge clock) disable iff (reset)
      ctrl_status.skipping && !csr_fire |-> !out_load)
      else $error("result while skipping trailing bytes");

   // an idle parser never loads a result
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      ctrl_status.idle |-> !out_load)
      else $error("result while idle");

endmodule
`default_nettype wire
